// ===== hdl/pausable_frame_clock_fps_macros.svh =====
// assertion macros shared by the frame clock rtl
`ifndef PAUSABLE_FRAME_CLOCK_FPS_MACROS_SVH
`define PAUSABLE_FRAME_CLOCK_FPS_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define PFC_ASSERT_NOW(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define PFC_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== hdl/pfc_fps_pkg.sv =====
// shared constants, types and ring helpers for the frame clock
package pfc_fps_pkg;

   localparam int TIME_W    = 32;
   localparam int CMD_W     = 3;
   localparam int CFG_W     = 16;
   localparam int CSR_IDX_W = 2;
   localparam int FPS_W     = 8;
   localparam int DEPTH     = 128;
   localparam int PTR_W     = $clog2(DEPTH);
   localparam int CNT_W     = $clog2(DEPTH + 1);

   localparam logic [CMD_W-1:0] CMD_TOGGLE   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PAUSE    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_CONTINUE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_REBASE   = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_STEP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW   = 2'd1;

   localparam logic [CFG_W-1:0] MAX_STEP_RST = 16'd50;
   localparam logic [CFG_W-1:0] WINDOW_RST   = 16'd1000;

   typedef struct packed {
      logic [CFG_W-1:0] max_step_ms;
      logic [CFG_W-1:0] window_ms;
   } cfg_type;

   typedef struct packed {
      logic [TIME_W-1:0] game_time_ms;
      logic [TIME_W-1:0] game_step_ms;
      logic [TIME_W-1:0] real_step_ms;
      logic              is_paused;
      logic [FPS_W-1:0]  frames_in_window;
   } rsp_data_type;

   typedef struct packed {
      logic              sub;
      logic [TIME_W-1:0] a;
      logic [TIME_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [TIME_W-1:0] sum;
      logic              carry;
   } alu_rsp_type;

   // ring pointer plus offset, offset below depth
   function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] ptr,
                                                  input logic [PTR_W-1:0] off);
      logic [PTR_W:0] s;
      s = {1'b0, ptr} + {1'b0, off};
      if (s >= (PTR_W+1)'(DEPTH)) begin
         s = s - (PTR_W+1)'(DEPTH);
      end
      return s[PTR_W-1:0];
   endfunction

endpackage

// ===== hdl/pfc_fps_if.sv =====
// channel interfaces of the frame clock: request, response and csr write
interface pfc_fps_req_if import pfc_fps_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [TIME_W-1:0] now_ms;
   modport source (output valid, output cmd, output now_ms, input ready);
   modport sink   (input valid, input cmd, input now_ms, output ready);
endinterface

interface pfc_fps_rsp_if import pfc_fps_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] game_time_ms;
   logic [TIME_W-1:0] game_step_ms;
   logic [TIME_W-1:0] real_step_ms;
   logic              is_paused;
   logic [FPS_W-1:0]  frames_in_window;
   modport source (output valid, output game_time_ms, output game_step_ms,
                   output real_step_ms, output is_paused, output frames_in_window,
                   input ready);
   modport sink   (input valid, input game_time_ms, input game_step_ms,
                   input real_step_ms, input is_paused, input frames_in_window,
                   output ready);
endinterface

interface pfc_fps_csr_if import pfc_fps_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/pausable_frame_clock_fps.sv =====
// pausable frame clock with sliding-window frame count, top level
//
// req_bus carries one beat per frame: cmd and now_ms, a wrapping real-time stamp in ms.
// rsp_bus returns exactly one beat per request: game time, game and real steps,
// pause flag and the number of frame stamps inside the last window_ms.
// csr_bus writes max_step_ms (index 0) and window_ms (index 1); it is always ready,
// other indexes are ignored. write only while no frame is in flight.
// steps: a rebase beat goes from the rebase state to done; a frame beat runs flip, real
// step, then game time, cap, compare and time base (skipped while paused), game step,
// window, read, check steps that drop each expired stamp from the ring of 128, write and
// done. the sequencer shares one add/subtract unit and one ring read port among them.
// req_bus.ready is high only while the sequencer is idle, so one frame at a time.
// a finished result sits in an output register; the next request is taken while it
// waits, and the sequencer holds its own result until that register frees up.
// reset (synchronous, active high) clears the clock state, pause flag, ring count and
// restores max_step_ms 50 and window_ms 1000; the stamp ram is not cleared.
module pausable_frame_clock_fps import pfc_fps_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   pfc_fps_req_if.sink    req_bus,
   pfc_fps_rsp_if.source  rsp_bus,
   pfc_fps_csr_if.sink    csr_bus
);
   cfg_type      cfg_ff, cfg_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_data_ff, rsp_data_in;
   logic         seq_out_valid;
   logic         seq_out_ready;
   rsp_data_type seq_out_data;
   logic         load;

   pfc_fps_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_cmd    (req_bus.cmd),
      .in_now    (req_bus.now_ms),
      .out_valid (seq_out_valid),
      .out_ready (seq_out_ready),
      .out_data  (seq_out_data)
   );

   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_MAX_STEP: cfg_in.max_step_ms = csr_bus.data;
            CSR_WINDOW:   cfg_in.window_ms   = csr_bus.data;
            default:      cfg_in             = cfg_ff;
         endcase
      end
   end

   assign seq_out_ready = !rsp_valid_ff || rsp_bus.ready;
   assign load          = seq_out_valid && seq_out_ready;

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = seq_out_data;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '{max_step_ms: MAX_STEP_RST, window_ms: WINDOW_RST};
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.game_time_ms     = rsp_data_ff.game_time_ms;
   assign rsp_bus.game_step_ms     = rsp_data_ff.game_step_ms;
   assign rsp_bus.real_step_ms     = rsp_data_ff.real_step_ms;
   assign rsp_bus.is_paused        = rsp_data_ff.is_paused;
   assign rsp_bus.frames_in_window = rsp_data_ff.frames_in_window;
endmodule

// ===== hdl/pfc_fps_ram.sv =====
// generic simple dual-port ram with registered read
module pfc_fps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== hdl/pfc_fps_alu.sv =====
// shared 32-bit add / subtract unit with carry-borrow out
module pfc_fps_alu import pfc_fps_pkg::*; (
   input  alu_req_type req,
   output alu_rsp_type rsp
);
   logic [TIME_W:0] wide;

   always_comb begin
      if (req.sub) begin
         wide = {1'b0, req.a} - {1'b0, req.b};
      end else begin
         wide = {1'b0, req.a} + {1'b0, req.b};
      end
      rsp.sum   = wide[TIME_W-1:0];
      rsp.carry = wide[TIME_W];
   end
endmodule

// ===== hdl/pfc_fps_seq.sv =====
// sequencer for the game clock and stamp ring, driving the shared alu
`include "pausable_frame_clock_fps_macros.svh"
module pfc_fps_seq import pfc_fps_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [CMD_W-1:0]  in_cmd,
   input  logic [TIME_W-1:0] in_now,
   output logic              out_valid,
   input  logic              out_ready,
   output rsp_data_type      out_data
);
   typedef enum logic [13:0] {
      S_IDLE   = 14'b00000000000001,
      S_REBASE = 14'b00000000000010,
      S_FLIP   = 14'b00000000000100,
      S_RSTEP  = 14'b00000000001000,
      S_GT     = 14'b00000000010000,
      S_CAP    = 14'b00000000100000,
      S_CMP    = 14'b00000001000000,
      S_TB     = 14'b00000010000000,
      S_GSTEP  = 14'b00000100000000,
      S_WIN    = 14'b00001000000000,
      S_RD     = 14'b00010000000000,
      S_CHK    = 14'b00100000000000,
      S_WRITE  = 14'b01000000000000,
      S_DONE   = 14'b10000000000000
   } state_type;

   state_type         state_ff, state_in;
   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [TIME_W-1:0] time_base_ff, time_base_in;
   logic [TIME_W-1:0] game_time_ff, game_time_in;
   logic [TIME_W-1:0] real_time_ff, real_time_in;
   logic [TIME_W-1:0] pause_start_ff, pause_start_in;
   logic              paused_ff, paused_in;
   logic [TIME_W-1:0] tmp_ff, tmp_in;
   logic [TIME_W-1:0] gt_new_ff, gt_new_in;
   logic [TIME_W-1:0] game_step_ff, game_step_in;
   logic [TIME_W-1:0] real_step_ff, real_step_in;
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   alu_req_type       alu_req;
   alu_rsp_type       alu_rsp;
   logic              flip;
   logic              ram_we;
   logic [PTR_W-1:0]  ram_waddr;
   logic [PTR_W-1:0]  ram_raddr;
   logic [TIME_W-1:0] ram_rdata;

   pfc_fps_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   pfc_fps_ram #(
      .WIDTH (TIME_W),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (real_time_ff),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign flip = (cmd_ff == CMD_TOGGLE) ||
                 ((cmd_ff == CMD_PAUSE) && !paused_ff) ||
                 ((cmd_ff == CMD_CONTINUE) && paused_ff);

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      now_in         = now_ff;
      time_base_in   = time_base_ff;
      game_time_in   = game_time_ff;
      real_time_in   = real_time_ff;
      pause_start_in = pause_start_ff;
      paused_in      = paused_ff;
      tmp_in         = tmp_ff;
      gt_new_in      = gt_new_ff;
      game_step_in   = game_step_ff;
      real_step_in   = real_step_ff;
      head_in        = head_ff;
      count_in       = count_ff;
      alu_req        = '{sub: 1'b1, a: '0, b: '0};
      ram_we         = 1'b0;
      ram_waddr      = ring_add(head_ff, count_ff[PTR_W-1:0]);
      ram_raddr      = head_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               cmd_in   = in_cmd;
               now_in   = in_now;
               state_in = (in_cmd == CMD_REBASE) ? S_REBASE : S_FLIP;
            end
         end
         S_REBASE: begin
            time_base_in = now_ff;
            game_time_in = '0;
            game_step_in = '0;
            real_step_in = '0;
            state_in     = S_DONE;
         end
         S_FLIP: begin
            // continuing uses the previous frame's real time
            alu_req = '{sub: 1'b1, a: real_time_ff, b: pause_start_ff};
            if (flip) begin
               paused_in = !paused_ff;
               if (paused_ff) begin
                  time_base_in = alu_rsp.sum;
               end else begin
                  pause_start_in = game_time_ff;
               end
            end
            state_in = S_RSTEP;
         end
         S_RSTEP: begin
            alu_req      = '{sub: 1'b1, a: now_ff, b: real_time_ff};
            real_step_in = alu_rsp.sum;
            real_time_in = now_ff;
            gt_new_in    = game_time_ff;
            state_in     = paused_ff ? S_GSTEP : S_GT;
         end
         S_GT: begin
            alu_req   = '{sub: 1'b1, a: now_ff, b: time_base_ff};
            gt_new_in = alu_rsp.sum;
            state_in  = S_CAP;
         end
         S_CAP: begin
            alu_req  = '{sub: 1'b0, a: game_time_ff, b: TIME_W'(cfg.max_step_ms)};
            tmp_in   = alu_rsp.sum;
            state_in = S_CMP;
         end
         S_CMP: begin
            alu_req  = '{sub: 1'b1, a: tmp_ff, b: gt_new_ff};
            state_in = alu_rsp.carry ? S_TB : S_GSTEP;
         end
         S_TB: begin
            // base plus excess equals now minus cap
            alu_req      = '{sub: 1'b1, a: now_ff, b: tmp_ff};
            time_base_in = alu_rsp.sum;
            gt_new_in    = tmp_ff;
            state_in     = S_GSTEP;
         end
         S_GSTEP: begin
            alu_req      = '{sub: 1'b1, a: gt_new_ff, b: game_time_ff};
            game_step_in = alu_rsp.sum;
            game_time_in = gt_new_ff;
            state_in     = S_WIN;
         end
         S_WIN: begin
            alu_req  = '{sub: 1'b1, a: real_time_ff, b: TIME_W'(cfg.window_ms)};
            tmp_in   = alu_rsp.sum;
            state_in = alu_rsp.carry ? S_WRITE : S_RD;
         end
         S_RD: begin
            state_in = (count_ff == '0) ? S_WRITE : S_CHK;
         end
         S_CHK: begin
            // fetch the next stamp ahead, one drop per cycle
            alu_req   = '{sub: 1'b1, a: tmp_ff, b: ram_rdata};
            ram_raddr = ring_add(head_ff, PTR_W'(1));
            if (!alu_rsp.carry) begin
               head_in  = ring_add(head_ff, PTR_W'(1));
               count_in = count_ff - CNT_W'(1);
               state_in = (count_ff == CNT_W'(1)) ? S_WRITE : S_CHK;
            end else begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            ram_we = 1'b1;
            if (count_ff == CNT_W'(DEPTH)) begin
               ram_waddr = head_ff;
               head_in   = ring_add(head_ff, PTR_W'(1));
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         time_base_ff   <= '0;
         game_time_ff   <= '0;
         real_time_ff   <= '0;
         pause_start_ff <= '0;
         paused_ff      <= 1'b0;
         head_ff        <= '0;
         count_ff       <= '0;
      end else begin
         state_ff       <= state_in;
         time_base_ff   <= time_base_in;
         game_time_ff   <= game_time_in;
         real_time_ff   <= real_time_in;
         pause_start_ff <= pause_start_in;
         paused_ff      <= paused_in;
         head_ff        <= head_in;
         count_ff       <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      now_ff       <= now_in;
      tmp_ff       <= tmp_in;
      gt_new_ff    <= gt_new_in;
      game_step_ff <= game_step_in;
      real_step_ff <= real_step_in;
   end

   assign in_ready  = (state_ff == S_IDLE);
   assign out_valid = (state_ff == S_DONE);
   assign out_data  = '{game_time_ms:     game_time_ff,
                        game_step_ms:     game_step_ff,
                        real_step_ms:     real_step_ff,
                        is_paused:        paused_ff,
                        frames_in_window: FPS_W'(count_ff)};

   `PFC_ASSERT_NOW(a_count_le_depth, 1'b1, count_ff <= CNT_W'(DEPTH), "ring count over depth")
   `PFC_ASSERT_NOW(a_chk_not_empty, state_ff == S_CHK, count_ff != '0, "ring check on empty ring")
   `PFC_ASSERT_NEXT(a_accept_busy, in_valid && state_ff == S_IDLE, state_ff != S_IDLE, "accepted beat not started")
   `PFC_ASSERT_NEXT(a_pause_in_flip, !reset && state_ff != S_FLIP, $stable(paused_ff), "pause flag moved outside flip step")
endmodule
